/* sv/bcct_pkg.sv */
// shared constants, codes and controller/datapath interface types for the contour tracer
package bcct_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = (COL_W > ROW_W ? COL_W : ROW_W) + 1;
    localparam int CRD_W      = DIM_W + 1;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int STEP_LIMIT = 4 * MAX_WIDTH * MAX_HEIGHT;
    localparam int STEP_W     = $clog2(STEP_LIMIT + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_DIM_W  = 9;
    localparam int OPAC_W     = 8;
    localparam int OFFS_W     = 16;
    localparam int POINT_W    = 17;
    localparam int MARK_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIMPLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET   = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_END   = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        E_TOP    = 2'd0,
        E_LEFT   = 2'd1,
        E_BOTTOM = 2'd2,
        E_RIGHT  = 2'd3
    } edge_t;

    typedef enum logic [1:0] {
        PR_SCAN    = 2'd0,
        PR_SCAN_NB = 2'd1,
        PR_CAND    = 2'd2,
        PR_CAND_NB = 2'd3
    } probe_sel_t;

    typedef struct packed {
        logic       load;
        logic       clr_start;
        logic       clr_step;
        logic       probe;
        probe_sel_t probe_sel;
        logic       edge_rd;
        logic       edge_rd_scan;
        logic       mark_wr;
        logic       walk_begin;
        logic       cand_next;
        logic       do_move;
        logic       no_move;
        logic       step_end;
        logic       scan_adv;
        logic       marks_latch;
        logic       k_next;
        logic       trace_start;
        logic       res_load;
        kind_t      res_kind;
        logic       res_scan_pt;
        logic       emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic size_wr;
        logic clr_last;
        logic load_zero;
        logic scan_end;
        logic probe_set;
        logic cand_last;
        logic k_marked;
        logic k_last;
        logic k_bottom;
        logic closed;
        logic pt_flag;
        logic simple;
        logic out_free;
    } dp_sts_t;

endpackage

/* sv/bcct_ram.sv */
// generic single-write, single-read ram with registered read data
module bcct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/bcct_dp.sv */
// tracer datapath: configuration, counters, pixel and edge-mark memories, result register
module bcct_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bcct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcct_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [bcct_pkg::OPAC_W-1:0]      pixel_opacity,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [1:0]                       kind,
    output logic signed [bcct_pkg::POINT_W-1:0] point_x,
    output logic signed [bcct_pkg::POINT_W-1:0] point_y,
    input  bcct_pkg::ctl_cmd_t               cmd,
    output bcct_pkg::dp_sts_t                sts
);

    localparam int CRD_W = bcct_pkg::CRD_W;
    localparam int DIM_W = bcct_pkg::DIM_W;
    localparam int ROW_W = bcct_pkg::ROW_W;
    localparam int COL_W = bcct_pkg::COL_W;
    localparam logic signed [CRD_W-1:0] ONE = CRD_W'(1);

    logic [bcct_pkg::OPAC_W-1:0]    bg_reg;
    logic                           simple_reg;
    logic [bcct_pkg::CFG_DIM_W-1:0] w_raw_reg, h_raw_reg;
    logic [bcct_pkg::OFFS_W-1:0]    xoff_reg, yoff_reg;
    logic [DIM_W-1:0]               eff_w, eff_h;

    logic [ROW_W-1:0]   load_row_reg, clr_row_reg, tr_reg;
    logic [COL_W-1:0]   load_col_reg, clr_col_reg, tc_reg, scan_col_reg;
    logic [DIM_W-1:0]   scan_row_reg;
    bcct_pkg::edge_t    cur_reg, last_reg, start_reg, p_edge_reg, k_reg;
    logic [bcct_pkg::STEP_W-1:0] steps_reg;
    logic               cand_reg;
    logic signed [CRD_W-1:0] p_row_reg, p_col_reg;
    logic               probe_oob_reg;
    logic [bcct_pkg::MARK_W-1:0] marks_reg;
    logic               pt_flag_reg;
    logic [DIM_W-1:0]   pt_x_reg, pt_y_reg;
    bcct_pkg::kind_t    res_kind_reg;

    logic               out_valid_reg;
    bcct_pkg::kind_t    out_kind_reg;
    logic [bcct_pkg::POINT_W-1:0] out_x_reg, out_y_reg;

    logic               opq_rdata;
    logic [bcct_pkg::MARK_W-1:0] edge_rdata;
    logic               opq_wdata;
    logic [bcct_pkg::ADDR_W-1:0] opq_raddr, edge_waddr, edge_raddr;
    logic [bcct_pkg::MARK_W-1:0] edge_wdata;
    logic               edge_we;

    logic signed [CRD_W-1:0] pr_r, pr_c, cand_r, cand_c, scan_r_s, scan_c_s;
    logic signed [1:0]  dr, dc;
    bcct_pkg::edge_t    cand_e;
    logic               pr_inb;
    logic               size_wr;
    logic [DIM_W-1:0]   corner_x, corner_y;

    function automatic logic signed [CRD_W-1:0] nb_row(
        input logic signed [CRD_W-1:0] r,
        input bcct_pkg::edge_t e
    );
        if (e == bcct_pkg::E_TOP)
            nb_row = r - ONE;
        else if (e == bcct_pkg::E_BOTTOM)
            nb_row = r + ONE;
        else
            nb_row = r;
    endfunction

    function automatic logic signed [CRD_W-1:0] nb_col(
        input logic signed [CRD_W-1:0] c,
        input bcct_pkg::edge_t e
    );
        if (e == bcct_pkg::E_LEFT)
            nb_col = c - ONE;
        else if (e == bcct_pkg::E_RIGHT)
            nb_col = c + ONE;
        else
            nb_col = c;
    endfunction

    // size in use, clamped to 1..max
    always_comb
    begin
        if (w_raw_reg == '0)
            eff_w = DIM_W'(1);
        else if (32'(w_raw_reg) > 32'(bcct_pkg::MAX_WIDTH))
            eff_w = DIM_W'(bcct_pkg::MAX_WIDTH);
        else
            eff_w = DIM_W'(w_raw_reg);
        if (h_raw_reg == '0)
            eff_h = DIM_W'(1);
        else if (32'(h_raw_reg) > 32'(bcct_pkg::MAX_HEIGHT))
            eff_h = DIM_W'(bcct_pkg::MAX_HEIGHT);
        else
            eff_h = DIM_W'(h_raw_reg);
    end

    assign size_wr = cfg_we && (cfg_index == bcct_pkg::CFG_WIDTH ||
                                cfg_index == bcct_pkg::CFG_HEIGHT);

    // candidate pixel for the next edge, in the order the follower tries them
    always_comb
    begin
        unique case (cur_reg)
            bcct_pkg::E_RIGHT:
            begin
                dr = -2'sd1;
                dc = cand_reg ? 2'sd1 : 2'sd0;
                cand_e = cand_reg ? bcct_pkg::E_BOTTOM : bcct_pkg::E_RIGHT;
            end
            bcct_pkg::E_TOP:
            begin
                dr = cand_reg ? -2'sd1 : 2'sd0;
                dc = -2'sd1;
                cand_e = cand_reg ? bcct_pkg::E_RIGHT : bcct_pkg::E_TOP;
            end
            bcct_pkg::E_LEFT:
            begin
                dr = 2'sd1;
                dc = cand_reg ? -2'sd1 : 2'sd0;
                cand_e = cand_reg ? bcct_pkg::E_TOP : bcct_pkg::E_LEFT;
            end
            default:
            begin
                dr = cand_reg ? 2'sd1 : 2'sd0;
                dc = 2'sd1;
                cand_e = cand_reg ? bcct_pkg::E_LEFT : bcct_pkg::E_BOTTOM;
            end
        endcase
        cand_r = $signed(CRD_W'(tr_reg)) + CRD_W'(dr);
        cand_c = $signed(CRD_W'(tc_reg)) + CRD_W'(dc);
    end

    assign scan_r_s = $signed(CRD_W'(scan_row_reg));
    assign scan_c_s = $signed(CRD_W'(scan_col_reg));

    always_comb
    begin
        unique case (cmd.probe_sel)
            bcct_pkg::PR_SCAN:
            begin
                pr_r = scan_r_s;
                pr_c = scan_c_s;
            end
            bcct_pkg::PR_SCAN_NB:
            begin
                pr_r = nb_row(scan_r_s, k_reg);
                pr_c = nb_col(scan_c_s, k_reg);
            end
            bcct_pkg::PR_CAND:
            begin
                pr_r = cand_r;
                pr_c = cand_c;
            end
            default:
            begin
                pr_r = nb_row(p_row_reg, p_edge_reg);
                pr_c = nb_col(p_col_reg, p_edge_reg);
            end
        endcase
        pr_inb = (pr_r >= 0) && (pr_c >= 0) &&
                 (pr_r < $signed(CRD_W'(eff_h))) && (pr_c < $signed(CRD_W'(eff_w)));
    end

    // corner of the current pixel on the current edge
    always_comb
    begin
        corner_x = DIM_W'(tc_reg);
        corner_y = DIM_W'(tr_reg);
        if (cur_reg == bcct_pkg::E_TOP || cur_reg == bcct_pkg::E_RIGHT)
            corner_x = DIM_W'(tc_reg) + DIM_W'(1);
        if (cur_reg == bcct_pkg::E_RIGHT || cur_reg == bcct_pkg::E_BOTTOM)
            corner_y = DIM_W'(tr_reg) + DIM_W'(1);
    end

    assign opq_wdata  = (pixel_opacity != bg_reg);
    assign opq_raddr  = {pr_r[ROW_W-1:0], pr_c[COL_W-1:0]};
    assign edge_we    = cmd.clr_step || cmd.mark_wr;
    assign edge_waddr = cmd.clr_step ? {clr_row_reg, clr_col_reg} : {tr_reg, tc_reg};
    assign edge_wdata = cmd.clr_step ? '0 :
                        (edge_rdata | (bcct_pkg::MARK_W'(1) << cur_reg));
    assign edge_raddr = cmd.edge_rd_scan ? {scan_row_reg[ROW_W-1:0], scan_col_reg}
                                         : {tr_reg, tc_reg};

    bcct_ram #(.WIDTH(1), .DEPTH(bcct_pkg::MEM_DEPTH)) u_opq_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr ({load_row_reg, load_col_reg}),
        .wdata (opq_wdata),
        .re    (cmd.probe),
        .raddr (opq_raddr),
        .rdata (opq_rdata)
    );

    bcct_ram #(.WIDTH(bcct_pkg::MARK_W), .DEPTH(bcct_pkg::MEM_DEPTH)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (cmd.edge_rd),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    always_comb
    begin
        sts.size_wr   = size_wr;
        sts.clr_last  = ((DIM_W'(clr_col_reg) + DIM_W'(1)) == eff_w) &&
                        ((DIM_W'(clr_row_reg) + DIM_W'(1)) == eff_h);
        sts.load_zero = (load_row_reg == '0) && (load_col_reg == '0);
        sts.scan_end  = (scan_row_reg >= eff_h);
        sts.probe_set = !probe_oob_reg && opq_rdata;
        sts.cand_last = cand_reg;
        sts.k_marked  = marks_reg[k_reg];
        sts.k_last    = (k_reg == bcct_pkg::E_RIGHT);
        sts.k_bottom  = (k_reg == bcct_pkg::E_BOTTOM);
        sts.closed    = ((DIM_W'(tr_reg) == scan_row_reg) && (tc_reg == scan_col_reg) &&
                         (cur_reg == start_reg)) ||
                        ((steps_reg + bcct_pkg::STEP_W'(1)) ==
                         bcct_pkg::STEP_W'(bcct_pkg::STEP_LIMIT));
        sts.pt_flag   = pt_flag_reg;
        sts.simple    = simple_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg        <= '0;
            simple_reg    <= 1'b0;
            w_raw_reg     <= bcct_pkg::CFG_DIM_W'(bcct_pkg::MAX_WIDTH);
            h_raw_reg     <= bcct_pkg::CFG_DIM_W'(bcct_pkg::MAX_HEIGHT);
            xoff_reg      <= '0;
            yoff_reg      <= '0;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            clr_row_reg   <= '0;
            clr_col_reg   <= '0;
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
            tr_reg        <= '0;
            tc_reg        <= '0;
            cur_reg       <= bcct_pkg::E_TOP;
            last_reg      <= bcct_pkg::E_TOP;
            start_reg     <= bcct_pkg::E_TOP;
            p_edge_reg    <= bcct_pkg::E_TOP;
            k_reg         <= bcct_pkg::E_TOP;
            steps_reg     <= '0;
            cand_reg      <= 1'b0;
            p_row_reg     <= '0;
            p_col_reg     <= '0;
            probe_oob_reg <= 1'b1;
            marks_reg     <= '0;
            pt_flag_reg   <= 1'b0;
            pt_x_reg      <= '0;
            pt_y_reg      <= '0;
            res_kind_reg  <= bcct_pkg::KIND_DONE;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= bcct_pkg::KIND_DONE;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bcct_pkg::CFG_BACKGROUND: bg_reg     <= cfg_data[bcct_pkg::OPAC_W-1:0];
                    bcct_pkg::CFG_SIMPLE:     simple_reg <= cfg_data[0];
                    bcct_pkg::CFG_WIDTH:      w_raw_reg  <= cfg_data[bcct_pkg::CFG_DIM_W-1:0];
                    bcct_pkg::CFG_HEIGHT:     h_raw_reg  <= cfg_data[bcct_pkg::CFG_DIM_W-1:0];
                    bcct_pkg::CFG_X_OFFSET:   xoff_reg   <= cfg_data[bcct_pkg::OFFS_W-1:0];
                    bcct_pkg::CFG_Y_OFFSET:   yoff_reg   <= cfg_data[bcct_pkg::OFFS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // edge-mark clearing sweep over the image in use
            if (cmd.clr_start || size_wr)
            begin
                clr_row_reg <= '0;
                clr_col_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                if ((DIM_W'(clr_col_reg) + DIM_W'(1)) == eff_w)
                begin
                    clr_col_reg <= '0;
                    clr_row_reg <= clr_row_reg + ROW_W'(1);
                end
                else
                begin
                    clr_col_reg <= clr_col_reg + COL_W'(1);
                end
            end

            if (size_wr)
            begin
                load_row_reg <= '0;
                load_col_reg <= '0;
            end
            else if (cmd.load)
            begin
                if ((DIM_W'(load_col_reg) + DIM_W'(1)) == eff_w)
                begin
                    load_col_reg <= '0;
                    if ((DIM_W'(load_row_reg) + DIM_W'(1)) == eff_h)
                        load_row_reg <= '0;
                    else
                        load_row_reg <= load_row_reg + ROW_W'(1);
                end
                else
                begin
                    load_col_reg <= load_col_reg + COL_W'(1);
                end
            end

            if (size_wr || cmd.load)
            begin
                scan_row_reg <= '0;
                scan_col_reg <= '0;
                tr_reg       <= '0;
                tc_reg       <= '0;
                cur_reg      <= bcct_pkg::E_TOP;
                last_reg     <= bcct_pkg::E_TOP;
                start_reg    <= bcct_pkg::E_TOP;
                steps_reg    <= '0;
            end
            else
            begin
                if (cmd.scan_adv)
                begin
                    if ((DIM_W'(scan_col_reg) + DIM_W'(1)) == eff_w)
                    begin
                        scan_col_reg <= '0;
                        scan_row_reg <= scan_row_reg + DIM_W'(1);
                    end
                    else
                    begin
                        scan_col_reg <= scan_col_reg + COL_W'(1);
                    end
                end

                if (cmd.trace_start)
                begin
                    tr_reg    <= scan_row_reg[ROW_W-1:0];
                    tc_reg    <= scan_col_reg;
                    cur_reg   <= k_reg;
                    last_reg  <= k_reg;
                    start_reg <= k_reg;
                    steps_reg <= '0;
                end

                if (cmd.walk_begin)
                begin
                    pt_flag_reg <= (last_reg != cur_reg);
                    if (last_reg != cur_reg)
                    begin
                        pt_x_reg <= corner_x;
                        pt_y_reg <= corner_y;
                    end
                    last_reg <= cur_reg;
                    cand_reg <= 1'b0;
                end

                if (cmd.cand_next)
                    cand_reg <= 1'b1;

                if (cmd.do_move)
                begin
                    tr_reg  <= p_row_reg[ROW_W-1:0];
                    tc_reg  <= p_col_reg[COL_W-1:0];
                    cur_reg <= p_edge_reg;
                end
                else if (cmd.no_move)
                begin
                    cur_reg <= bcct_pkg::edge_t'(cur_reg + 2'd1);
                end

                if (cmd.step_end)
                    steps_reg <= steps_reg + bcct_pkg::STEP_W'(1);
            end

            if (cmd.probe)
            begin
                probe_oob_reg <= !pr_inb;
                if (cmd.probe_sel == bcct_pkg::PR_CAND)
                begin
                    p_row_reg  <= cand_r;
                    p_col_reg  <= cand_c;
                    p_edge_reg <= cand_e;
                end
            end

            if (cmd.marks_latch)
            begin
                marks_reg <= edge_rdata;
                k_reg     <= bcct_pkg::E_TOP;
            end
            else if (cmd.k_next)
            begin
                k_reg <= bcct_pkg::edge_t'(k_reg + 2'd1);
            end

            if (cmd.res_load)
            begin
                res_kind_reg <= cmd.res_kind;
                if (cmd.res_scan_pt)
                begin
                    pt_x_reg <= DIM_W'(scan_col_reg);
                    pt_y_reg <= scan_row_reg;
                end
            end

            // result register, one transfer per fetch
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= res_kind_reg;
                if (res_kind_reg == bcct_pkg::KIND_POINT)
                begin
                    out_x_reg <= bcct_pkg::POINT_W'(pt_x_reg) +
                                 bcct_pkg::POINT_W'($signed(xoff_reg));
                    out_y_reg <= bcct_pkg::POINT_W'(pt_y_reg) +
                                 bcct_pkg::POINT_W'($signed(yoff_reg));
                end
                else
                begin
                    out_x_reg <= '0;
                    out_y_reg <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign point_x   = $signed(out_x_reg);
    assign point_y   = $signed(out_y_reg);

    a_mark_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_wr |-> (DIM_W'(tr_reg) < eff_h) && (DIM_W'(tc_reg) < eff_w))
        else $error("edge mark written outside the image");

    a_scan_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_adv |=> (DIM_W'(scan_col_reg) < eff_w))
        else $error("scan column left the row");

endmodule

/* sv/bcct_ctrl.sv */
// tracer controller: sequences scanning, edge following, clearing and result transfers
module bcct_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    output bcct_pkg::ctl_cmd_t   cmd,
    input  bcct_pkg::dp_sts_t    sts
);

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_DISPATCH = 14'b00000000000100,
        S_S_SET    = 14'b00000000001000,
        S_S_MARKS  = 14'b00000000010000,
        S_S_K      = 14'b00000000100000,
        S_S_KCHK   = 14'b00000001000000,
        S_W_BEGIN  = 14'b00000010000000,
        S_W_MARK   = 14'b00000100000000,
        S_W_P_RD   = 14'b00001000000000,
        S_W_P_CHK  = 14'b00010000000000,
        S_W_N_CHK  = 14'b00100000000000,
        S_W_END    = 14'b01000000000000,
        S_EMIT     = 14'b10000000000000
    } state_t;

    typedef enum logic [3:0] {
        PH_SCAN  = 4'b0001,
        PH_TRACE = 4'b0010,
        PH_CLOSE = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   silent_reg, silent_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        phase_next  = phase_reg;
        silent_next = silent_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == bcct_pkg::OP_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        phase_next = PH_SCAN;
                        if (sts.load_zero)
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = S_CLEAR;
                        end
                    end
                    else
                    begin
                        state_next = S_DISPATCH;
                    end
                end
            end
            S_DISPATCH:
            begin
                unique case (phase_reg)
                    PH_DONE:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = bcct_pkg::KIND_DONE;
                        state_next   = S_EMIT;
                    end
                    PH_CLOSE:
                    begin
                        phase_next   = PH_SCAN;
                        cmd.scan_adv = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_kind = bcct_pkg::KIND_END;
                        state_next   = S_EMIT;
                    end
                    PH_TRACE:
                    begin
                        state_next = S_W_BEGIN;
                    end
                    PH_SCAN:
                    begin
                        if (sts.scan_end)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            cmd.probe     = 1'b1;
                            cmd.probe_sel = bcct_pkg::PR_SCAN;
                            state_next    = S_S_SET;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SCAN;
                    end
                endcase
            end
            S_S_SET:
            begin
                if (sts.probe_set)
                begin
                    cmd.edge_rd      = 1'b1;
                    cmd.edge_rd_scan = 1'b1;
                    state_next       = S_S_MARKS;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_S_MARKS:
            begin
                cmd.marks_latch = 1'b1;
                state_next      = S_S_K;
            end
            S_S_K:
            begin
                if (sts.k_marked)
                begin
                    if (sts.k_last)
                    begin
                        cmd.scan_adv = 1'b1;
                        state_next   = S_DISPATCH;
                    end
                    else
                    begin
                        cmd.k_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.probe     = 1'b1;
                    cmd.probe_sel = bcct_pkg::PR_SCAN_NB;
                    state_next    = S_S_KCHK;
                end
            end
            S_S_KCHK:
            begin
                if (!sts.probe_set)
                begin
                    cmd.trace_start = 1'b1;
                    // holes in simple mode are followed and marked but not reported
                    if (sts.simple && sts.k_bottom)
                    begin
                        silent_next = 1'b1;
                        state_next  = S_W_BEGIN;
                    end
                    else
                    begin
                        phase_next      = PH_TRACE;
                        cmd.res_load    = 1'b1;
                        cmd.res_kind    = bcct_pkg::KIND_POINT;
                        cmd.res_scan_pt = 1'b1;
                        state_next      = S_EMIT;
                    end
                end
                else if (sts.k_last)
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_DISPATCH;
                end
                else
                begin
                    cmd.k_next = 1'b1;
                    state_next = S_S_K;
                end
            end
            S_W_BEGIN:
            begin
                cmd.walk_begin = 1'b1;
                cmd.edge_rd    = 1'b1;
                state_next     = S_W_MARK;
            end
            S_W_MARK:
            begin
                cmd.mark_wr = 1'b1;
                state_next  = S_W_P_RD;
            end
            S_W_P_RD:
            begin
                cmd.probe     = 1'b1;
                cmd.probe_sel = bcct_pkg::PR_CAND;
                state_next    = S_W_P_CHK;
            end
            S_W_P_CHK:
            begin
                if (sts.probe_set)
                begin
                    cmd.probe     = 1'b1;
                    cmd.probe_sel = bcct_pkg::PR_CAND_NB;
                    state_next    = S_W_N_CHK;
                end
                else if (sts.cand_last)
                begin
                    cmd.no_move = 1'b1;
                    state_next  = S_W_END;
                end
                else
                begin
                    cmd.cand_next = 1'b1;
                    state_next    = S_W_P_RD;
                end
            end
            S_W_N_CHK:
            begin
                if (!sts.probe_set)
                begin
                    cmd.do_move = 1'b1;
                    state_next  = S_W_END;
                end
                else if (sts.cand_last)
                begin
                    cmd.no_move = 1'b1;
                    state_next  = S_W_END;
                end
                else
                begin
                    cmd.cand_next = 1'b1;
                    state_next    = S_W_P_RD;
                end
            end
            S_W_END:
            begin
                cmd.step_end = 1'b1;
                if (silent_reg)
                begin
                    if (sts.closed)
                    begin
                        silent_next  = 1'b0;
                        cmd.scan_adv = 1'b1;
                        state_next   = S_DISPATCH;
                    end
                    else
                    begin
                        state_next = S_W_BEGIN;
                    end
                end
                else
                begin
                    if (sts.closed)
                        phase_next = PH_CLOSE;
                    if (sts.pt_flag)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = bcct_pkg::KIND_POINT;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_DISPATCH;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // a size write restarts everything behind a fresh clearing sweep
        if (sts.size_wr)
        begin
            state_next  = S_CLEAR;
            phase_next  = PH_SCAN;
            silent_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            phase_reg  <= PH_SCAN;
            silent_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            silent_reg <= silent_next;
        end
    end

    a_fetch_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == bcct_pkg::OP_FETCH) |=> (state_reg != S_IDLE))
        else $error("fetch transfer did not start work");

    a_load_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == bcct_pkg::OP_LOAD && sts.load_zero)
        |=> (state_reg == S_CLEAR))
        else $error("first pixel of an image did not start the mark sweep");

    a_silent_keeps_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_W_END && silent_reg) |-> (phase_reg == PH_SCAN))
        else $error("hidden hole walk left the scan phase");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !sts.out_free) |=> (state_reg == S_EMIT || sts.size_wr ||
                                                     $past(sts.size_wr)))
        else $error("result dropped while output stalled");

endmodule

/* sv/bitmap_crack_contour_tracer.sv */
// top level of the crack-following contour tracer
// Usage: configure through cfg_we/cfg_index/cfg_data while the block is idle, then send
// items on the in channel (valid/ready). op=0 loads the next pixel in raster order and
// gives no result; op=1 fetches exactly one result on the out channel: a corner point
// (kind 0, with offsets added), an end of path (kind 1) or scan finished (kind 2).
// A load is written to the pixel memory when it is accepted. A fetch scans past empty
// pixels, tests the neighbours of each set one and steps along edges while following
// an outline; every neighbour test goes through the single read port of the pixel
// memory.
// One item is in work at a time; in_ready is high only when the controller is idle.
// After reset, after the first pixel of each image and after a width or height write,
// the edge-mark memory is swept clear over the width*height pixels in use, one pixel a
// cycle, with in_ready low.
// Results sit in an output register; while the receiver stalls, loads are still taken,
// and a fetch waits for the register to be free before its result transfer.
module bitmap_crack_contour_tracer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bcct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcct_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [bcct_pkg::OPAC_W-1:0]         pixel_opacity,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          kind,
    output logic signed [bcct_pkg::POINT_W-1:0] point_x,
    output logic signed [bcct_pkg::POINT_W-1:0] point_y
);

    bcct_pkg::ctl_cmd_t cmd;
    bcct_pkg::dp_sts_t  sts;

    bcct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .cmd      (cmd),
        .sts      (sts)
    );

    bcct_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_opacity (pixel_opacity),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .kind          (kind),
        .point_x       (point_x),
        .point_y       (point_y),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
